// File: rtl/ecsc_pkg.sv
// Shared constants and types for the expiring card status cache.
// Used by ecsc_cell and expiring_card_status_cache_core; no dependencies.
package ecsc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam int TAG_W = 32;
	localparam int STAT_W = 8;
	localparam int TICK_W = 32;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [TICK_W-1:0] LIVE_TIME_RST = TICK_W'(60000);
	localparam logic [TICK_W-1:0] PENDING_TIME_RST = TICK_W'(5000);
	localparam logic [STAT_W-1:0] IN_PROGRESS_RST = STAT_W'(2);
	localparam logic [STAT_W-1:0] NOT_CACHED_RST = STAT_W'(0);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIVE_TIME = 2'd0,
		REG_PENDING_TIME = 2'd1,
		REG_IN_PROGRESS = 2'd2,
		REG_NOT_CACHED = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		CMD_LOOKUP = 1'b0,
		CMD_INSERT = 1'b1
	} cmd_t;

	// Query that travels down the row of cells, one cell per cycle.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
		logic [TAG_W-1:0] tag;
		logic [STAT_W-1:0] status;
		logic [TICK_W-1:0] now;
		logic [TICK_W-1:0] expiry;
		logic hit;
		logic [STAT_W-1:0] hit_status;
		logic stored;
		logic free_found;
		logic [IDX_W-1:0] free_idx;
	} token_t;

	// Broadcast fill of a free slot, decoded by each cell against its index.
	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] idx;
		logic [TAG_W-1:0] tag;
		logic [STAT_W-1:0] status;
		logic [TICK_W-1:0] expiry;
	} fill_t;

endpackage

// File: rtl/ecsc_cell.sv
// One cache slot with its stage of the query chain.
// Depends on ecsc_pkg for the token and fill types.
module ecsc_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ecsc_pkg::IDX_W-1:0] cell_idx,
	input  ecsc_pkg::token_t          tok_in,
	input  ecsc_pkg::fill_t           fill,
	output ecsc_pkg::token_t          tok_out
);
	import ecsc_pkg::*;

	logic [TAG_W-1:0] tag_q;
	logic [STAT_W-1:0] status_q;
	logic [TICK_W-1:0] expiry_q;
	logic used_q;
	logic valid_q;
	token_t tok_q;

	logic live;
	logic match;
	logic upd;
	logic take_free;
	logic fill_me;
	token_t tok_d;

	always_comb begin
		live = used_q && (expiry_q >= tok_in.now);
		match = tok_in.valid && live && (tag_q == tok_in.tag) && !tok_in.hit;
		upd = match && (tok_in.cmd == CMD_INSERT) && (status_q != tok_in.status);
		take_free = tok_in.valid && !live && !tok_in.free_found;
		fill_me = fill.en && (fill.idx == cell_idx);

		tok_d = tok_in;
		if (match) begin
			tok_d.hit = 1'b1;
			tok_d.hit_status = status_q;
		end
		if (upd) begin
			tok_d.stored = 1'b1;
		end
		if (take_free) begin
			tok_d.free_found = 1'b1;
			tok_d.free_idx = cell_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_d.valid;
			if (fill_me) begin
				used_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
		if (fill_me) begin
			tag_q <= fill.tag;
			status_q <= fill.status;
			expiry_q <= fill.expiry;
		end else if (upd) begin
			status_q <= tok_in.status;
		end
	end

	// The valid bit comes from the flop with reset; the payload has none.
	always_comb begin
		tok_out = tok_q;
		tok_out.valid = valid_q;
	end

endmodule

// File: rtl/expiring_card_status_cache_core.sv
// Top level of the expiring card status cache: configuration registers,
// the row of ecsc_cell slots and the result registers. Depends on ecsc_pkg.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  s_tuser command, s_tdata tag/status/now
//  m_*       out        m_tvalid / m_tready  m_tdata result_status/hit/stored/table_full
//  cfg_*     in         cfg_we (no wait)     cfg_index, cfg_data
//
// An accepted item enters the first cell and moves one cell per cycle. The
// last cell hands it to the result register (or, if that is still full, to
// the hold register), and m_tvalid is set as the result register is loaded.
// The block works on one item at a time: a new item is taken only after the
// previous one leaves the row, since busy_q clears as it does.
// Reset clears the used flag of every slot at once; there is no clearing pass.
// A result that is not taken is held, and one more finished result waits in a
// hold register. s_tready is low while an item is in the row and, beyond
// that, only while the hold register is full.
module expiring_card_status_cache_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input item.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [31:0] tag, [39:32] status, [71:40] now
	input  logic [71:0]                   s_tdata,
	// [0] command: 0 lookup, 1 insert or update
	input  logic [0:0]                    s_tuser,
	// Result item.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [7:0] result_status, [8] hit, [9] stored, [10] table_full, [15:11] zero
	output logic [15:0]                   m_tdata,
	// Configuration writes.
	input  logic                          cfg_we,
	input  logic [ecsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ecsc_pkg::CFG_W-1:0]    cfg_data
);
	import ecsc_pkg::*;

	// Configuration registers.
	logic [TICK_W-1:0] live_time_q;
	logic [TICK_W-1:0] pending_time_q;
	logic [STAT_W-1:0] in_progress_q;
	logic [STAT_W-1:0] not_cached_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_time_q <= LIVE_TIME_RST;
			pending_time_q <= PENDING_TIME_RST;
			in_progress_q <= IN_PROGRESS_RST;
			not_cached_q <= NOT_CACHED_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LIVE_TIME: live_time_q <= cfg_data[TICK_W-1:0];
				REG_PENDING_TIME: pending_time_q <= cfg_data[TICK_W-1:0];
				REG_IN_PROGRESS: in_progress_q <= cfg_data[STAT_W-1:0];
				REG_NOT_CACHED: not_cached_q <= cfg_data[STAT_W-1:0];
				default: ;
			endcase
		end
	end

	// Unpack the input item.
	logic [TAG_W-1:0] in_tag;
	logic [STAT_W-1:0] in_status;
	logic [TICK_W-1:0] in_now;

	assign in_tag = s_tdata[31:0];
	assign in_status = s_tdata[39:32];
	assign in_now = s_tdata[71:40];

	logic busy_q;
	logic hold_valid_q;
	logic accept;

	assign s_tready = !busy_q && !hold_valid_q;
	assign accept = s_tvalid && s_tready;

	// The expiry of a possible new entry is worked out once, as the item
	// enters, with a saturating add: an in-progress status gets the shorter
	// pending lifetime.
	logic [TICK_W-1:0] life;
	logic [TICK_W:0] exp_sum;
	token_t tok_head;

	always_comb begin
		life = (in_status == in_progress_q) ? pending_time_q : live_time_q;
		exp_sum = {1'b0, in_now} + {1'b0, life};

		tok_head.valid = accept;
		tok_head.cmd = cmd_t'(s_tuser[0]);
		tok_head.tag = in_tag;
		tok_head.status = in_status;
		tok_head.now = in_now;
		tok_head.expiry = exp_sum[TICK_W] ? {TICK_W{1'b1}} : exp_sum[TICK_W-1:0];
		tok_head.hit = 1'b0;
		tok_head.hit_status = '0;
		tok_head.stored = 1'b0;
		tok_head.free_found = 1'b0;
		tok_head.free_idx = '0;
	end

	// Row of cells. Token i is the input of cell i; the last one leaves the row.
	token_t tok_chain [ENTRIES+1];
	fill_t fill;

	assign tok_chain[0] = tok_head;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ecsc_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cell_idx(IDX_W'(i)),
			.tok_in(tok_chain[i]),
			.fill(fill),
			.tok_out(tok_chain[i+1])
		);
	end

	// Finish the item as it leaves the row. An insert with no live match goes
	// into the first slot that was not live, if the row reported one.
	token_t tok_tail;
	logic new_entry;
	logic no_room;
	logic [15:0] res_word;

	always_comb begin
		tok_tail = tok_chain[ENTRIES];
		new_entry = (tok_tail.cmd == CMD_INSERT) && !tok_tail.hit && tok_tail.free_found;
		no_room = (tok_tail.cmd == CMD_INSERT) && !tok_tail.hit && !tok_tail.free_found;

		fill.en = tok_tail.valid && new_entry;
		fill.idx = tok_tail.free_idx;
		fill.tag = tok_tail.tag;
		fill.status = tok_tail.status;
		fill.expiry = tok_tail.expiry;

		res_word = '0;
		if (tok_tail.cmd == CMD_LOOKUP) begin
			res_word[7:0] = tok_tail.hit ? tok_tail.hit_status : not_cached_q;
		end
		res_word[8] = tok_tail.hit;
		res_word[9] = tok_tail.stored || new_entry;
		res_word[10] = no_room;
	end

	// Output register plus one hold register for a result that finishes
	// while the previous one is still waiting.
	logic out_valid_q;
	logic [15:0] out_q;
	logic [15:0] hold_q;
	logic out_free;

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tok_tail.valid) begin
				busy_q <= 1'b0;
			end

			if (out_free) begin
				out_valid_q <= hold_valid_q || tok_tail.valid;
			end

			if (hold_valid_q) begin
				if (out_free) begin
					hold_valid_q <= tok_tail.valid;
				end
			end else if (tok_tail.valid && !out_free) begin
				hold_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= hold_valid_q ? hold_q : res_word;
		end
		if (tok_tail.valid && (hold_valid_q || !out_free)) begin
			hold_q <= res_word;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

endmodule
